// ===== hw/rtl/limit_order_book_matcher_unit_defines.svh =====
// Assertion helpers shared by the order book matcher RTL.
// Each macro checks on the rising edge of i_clk and is idle during reset.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LOBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LOBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lobm_pkg.sv =====
package lobm_pkg;

    // Default book geometry.
    localparam int NUM_SYMBOLS_DEF  = 4;
    localparam int PRICE_LEVELS_DEF = 256;
    localparam int LEVEL_DEPTH_DEF  = 8;

    // Fixed field widths.
    localparam int SYM_W  = 2;
    localparam int TICK_W = 8;
    localparam int SHR_W  = 20;
    localparam int ID_W   = 32;
    localparam int RMV_W  = 12;
    localparam int ENT_W  = SHR_W + ID_W;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    localparam logic [RMV_W-1:0] RMV_MAX = '1;

endpackage

// ===== hw/rtl/limit_order_book_matcher_unit.sv =====
// Channel    | Dir | Signals                        | Content
// -----------+-----+--------------------------------+------------------------------------------
// s_axis     | in  | tvalid tready tdata[63:0] tuser | symbol, tick, shares, ident; tuser side
// m_axis     | out | tvalid tready tdata[55:0] tuser | filled, rested, removed; tuser book_full
//
// After reset the level store is swept clear, all NUM_SYMBOLS*2*PRICE_LEVELS levels
// (2048 by default); no order transaction is accepted during the sweep.
// An order is taken in S_IDLE; each price level scanned passes through S_LRD, S_LCHK and
// S_ADV, plus S_ECHK once per resting entry touched; a buy scans at most tick+1 levels, a
// sell at most PRICE_LEVELS-tick levels, and the scan stops once the order is filled.
// The level store read is registered; any remainder is then queued through S_RRD and S_RCHK.
// A finished result waits in an output register; one new order is taken meanwhile.
module limit_order_book_matcher_unit
    import lobm_pkg::*;
#(
    parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
    parameter int PRICE_LEVELS = PRICE_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = LEVEL_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // Fields from bit 0: symbol_index[2], price_tick[8], share_count[20],
    // order_ident[32], zero pad[2].
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: order_side[1].
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // Fields from bit 0: filled_shares[20], rested_shares[20], orders_removed[12],
    // zero pad[4].
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: book_full[1].
    output logic                  o_m_axis_tuser
);

`include "limit_order_book_matcher_unit_defines.svh"

    localparam int LEVELS  = NUM_SYMBOLS * 2 * PRICE_LEVELS;
    localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
    localparam int LW  = $clog2(LEVELS);
    localparam int EW  = $clog2(ENTRIES);
    localparam int PW  = $clog2(PRICE_LEVELS);
    localparam int SW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW  = $clog2(LEVEL_DEPTH + 1);
    localparam int LVW = HW + CW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LRD, S_LCHK, S_ECHK, S_ADV, S_RRD, S_RCHK, S_DONE
    } t_state;

    // Level index of (symbol, side, tick).
    function automatic logic [LW-1:0] lvl_addr(input logic [SW-1:0] sym, input logic side,
                                               input logic [PW-1:0] p);
        logic [31:0] a;
        a = (32'(sym) * 32'd2 + 32'(side)) * PRICE_LEVELS + 32'(p);
        return LW'(a);
    endfunction

    // Entry address of a slot within a level.
    function automatic logic [EW-1:0] ent_addr(input logic [LW-1:0] lvl,
                                               input logic [HW-1:0] slot);
        logic [31:0] a;
        a = 32'(lvl) * LEVEL_DEPTH + 32'(slot);
        return EW'(a);
    endfunction

    // Memories.
    logic [LVW-1:0]   lvl_mem [LEVELS];
    logic [ENT_W-1:0] ent_mem [ENTRIES];
    logic [LVW-1:0]   r_lvl_rd;
    logic [ENT_W-1:0] r_ent_rd;

    logic             lvl_we, lvl_re, ent_we, ent_re;
    logic [LW-1:0]    lvl_waddr, lvl_raddr;
    logic [LVW-1:0]   lvl_wdata;
    logic [EW-1:0]    ent_waddr, ent_raddr;
    logic [ENT_W-1:0] ent_wdata;

    // Control and working registers.
    t_state              r_state, n_state;
    logic [LW-1:0]       r_clr, n_clr;
    logic [SW-1:0]       r_sym, n_sym;
    logic                r_side, n_side;
    logic [PW-1:0]       r_tick, n_tick;
    logic [PW-1:0]       r_p, n_p;
    logic [SHR_W-1:0]    r_left, n_left;
    logic [ID_W-1:0]     r_id, n_id;
    logic [HW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [SHR_W-1:0]    r_filled, n_filled;
    logic [SHR_W-1:0]    r_rested, n_rested;
    logic [RMV_W-1:0]    r_removed, n_removed;
    logic                r_full, n_full;
    logic                r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                r_out_user, n_out_user;

    // Decoded input fields.
    logic [SYM_W-1:0]  in_sym;
    logic [TICK_W-1:0] in_tick;
    logic [SHR_W-1:0]  in_shr;
    logic [ID_W-1:0]   in_id;
    logic [PW-1:0]     in_tick_sat;
    logic              in_ok;

    assign in_sym  = i_s_axis_tdata[SYM_W-1:0];
    assign in_tick = i_s_axis_tdata[SYM_W+TICK_W-1:SYM_W];
    assign in_shr  = i_s_axis_tdata[SYM_W+TICK_W+SHR_W-1:SYM_W+TICK_W];
    assign in_id   = i_s_axis_tdata[SYM_W+TICK_W+SHR_W+ID_W-1:SYM_W+TICK_W+SHR_W];
    assign in_tick_sat = (32'(in_tick) >= PRICE_LEVELS) ? PW'(PRICE_LEVELS - 1) : PW'(in_tick);
    assign in_ok = (32'(in_sym) < NUM_SYMBOLS) && (in_shr != '0);

    // Read data views.
    logic [HW-1:0]    rd_head;
    logic [CW-1:0]    rd_cnt;
    logic [SHR_W-1:0] ent_sh;
    logic [ID_W-1:0]  ent_id;
    assign rd_head = r_lvl_rd[LVW-1:CW];
    assign rd_cnt  = r_lvl_rd[CW-1:0];
    assign ent_sh  = r_ent_rd[ENT_W-1:ID_W];
    assign ent_id  = r_ent_rd[ID_W-1:0];

    logic [LW-1:0] cur_lvl, own_lvl;
    assign cur_lvl = lvl_addr(r_sym, ~r_side, r_p);
    assign own_lvl = lvl_addr(r_sym, r_side, r_tick);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Level store: one write and one read port, registered read.
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        if (lvl_re) begin
            r_lvl_rd <= lvl_mem[lvl_raddr];
        end
    end

    // Resting entry store: one write and one read port, registered read.
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_rd <= ent_mem[ent_raddr];
        end
    end

    // Matching sequencer.
    always_comb begin
        logic [SHR_W-1:0] d;
        logic [SHR_W-1:0] new_sh;
        logic [SHR_W-1:0] nl;
        logic [HW-1:0]    nh;
        logic [CW-1:0]    nc;
        logic [31:0]      pos_sum;
        logic [HW-1:0]    pos;

        n_state = r_state;   n_clr = r_clr;       n_sym = r_sym;       n_side = r_side;
        n_tick = r_tick;     n_p = r_p;           n_left = r_left;     n_id = r_id;
        n_head = r_head;     n_cnt = r_cnt;       n_filled = r_filled; n_rested = r_rested;
        n_removed = r_removed; n_full = r_full;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_data = r_out_data;
        n_out_user = r_out_user;
        lvl_we = 1'b0; lvl_re = 1'b0; ent_we = 1'b0; ent_re = 1'b0;
        lvl_waddr = cur_lvl; lvl_raddr = cur_lvl; lvl_wdata = '0;
        ent_waddr = '0; ent_raddr = '0; ent_wdata = '0;

        d = (ent_sh < r_left) ? ent_sh : r_left;
        new_sh = ent_sh - d;
        nl = r_left - d;
        nh = r_head;
        nc = r_cnt;
        pos_sum = 32'(rd_head) + 32'(rd_cnt);
        pos = HW'((pos_sum >= LEVEL_DEPTH) ? pos_sum - LEVEL_DEPTH : pos_sum);

        unique case (r_state)
            S_CLEAR: begin
                lvl_we = 1'b1;
                lvl_waddr = r_clr;
                if (r_clr == LW'(LEVELS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_sym = SW'(in_sym);
                    n_side = i_s_axis_tuser;
                    n_tick = in_tick_sat;
                    n_left = in_shr;
                    n_id = in_id;
                    n_filled = '0;
                    n_rested = '0;
                    n_removed = '0;
                    n_full = 1'b0;
                    n_p = i_s_axis_tuser ? PW'(PRICE_LEVELS - 1) : '0;
                    n_state = in_ok ? S_LRD : S_DONE;
                end
            end
            S_LRD: begin
                lvl_re = 1'b1;
                n_state = S_LCHK;
            end
            S_LCHK: begin
                n_head = rd_head;
                n_cnt = rd_cnt;
                if (rd_cnt != '0) begin
                    ent_re = 1'b1;
                    ent_raddr = ent_addr(cur_lvl, rd_head);
                    n_state = S_ECHK;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ECHK: begin
                // Fill against the head entry of the current level.
                n_left = nl;
                n_filled = r_filled + d;
                if (new_sh == '0) begin
                    nh = (r_head == HW'(LEVEL_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    nc = r_cnt - 1'b1;
                    n_removed = (r_removed == RMV_MAX) ? RMV_MAX : r_removed + 1'b1;
                end else begin
                    ent_we = 1'b1;
                    ent_waddr = ent_addr(cur_lvl, r_head);
                    ent_wdata = {new_sh, ent_id};
                end
                n_head = nh;
                n_cnt = nc;
                if ((nc != '0) && (nl != '0)) begin
                    ent_re = 1'b1;
                    ent_raddr = ent_addr(cur_lvl, nh);
                end else begin
                    lvl_we = 1'b1;
                    lvl_waddr = cur_lvl;
                    lvl_wdata = {nh, nc};
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                if ((r_left == '0) || (r_p == r_tick)) begin
                    n_state = S_RRD;
                end else begin
                    n_p = r_side ? r_p - 1'b1 : r_p + 1'b1;
                    n_state = S_LRD;
                end
            end
            S_RRD: begin
                if (r_left == '0) begin
                    n_state = S_DONE;
                end else begin
                    lvl_re = 1'b1;
                    lvl_raddr = own_lvl;
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                // Queue the remainder at its own level if there is room.
                if (32'(rd_cnt) < LEVEL_DEPTH) begin
                    ent_we = 1'b1;
                    ent_waddr = ent_addr(own_lvl, pos);
                    ent_wdata = {r_left, r_id};
                    lvl_we = 1'b1;
                    lvl_waddr = own_lvl;
                    lvl_wdata = {rd_head, rd_cnt + 1'b1};
                    n_rested = r_left;
                end else begin
                    n_full = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data = {{(OUT_DATA_W - 2*SHR_W - RMV_W){1'b0}},
                                  r_removed, r_rested, r_filled};
                    n_out_user = r_full;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_sym <= n_sym;         r_side <= n_side;     r_tick <= n_tick;
        r_p <= n_p;             r_left <= n_left;     r_id <= n_id;
        r_head <= n_head;       r_cnt <= n_cnt;       r_filled <= n_filled;
        r_rested <= n_rested;   r_removed <= n_removed; r_full <= n_full;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // Checks.
    `LOBM_ASSERT_IMP(a_full_rests_nothing, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[39:20] == 20'd0, "book_full result reports rested shares")
    `LOBM_ASSERT_IMP(a_level_count_bound, lvl_we, 32'(lvl_wdata[CW-1:0]) <= LEVEL_DEPTH, "level count written above queue depth")
    `LOBM_ASSERT_IMP(a_entry_from_nonempty, r_state == S_ECHK, r_cnt != '0, "entry matched from an empty level")
    `LOBM_ASSERT_NXT(a_accept_starts_work, i_s_axis_tvalid && o_s_axis_tready, r_state != S_IDLE, "accepted order did not start")

endmodule
